// ----- design/multichannel_pattern_pwm_assert.svh -----
// Assertion macros used by the multichannel pattern PWM top level.
`ifndef MULTICHANNEL_PATTERN_PWM_ASSERT_SVH
`define MULTICHANNEL_PATTERN_PWM_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define MPP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mpp assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define MPP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mpp assertion failed");

`endif

// ----- design/mpp_pkg.sv -----
// Types, opcodes and duty pattern ROM for the multichannel pattern PWM.
package mpp_pkg;

	localparam int PIN_FW = 5;
	localparam int LVL_W  = 6;
	localparam int PAT_W  = 32;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_SET  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [LVL_W-1:0] LVL_MAX = 6'd32;

	typedef struct packed {
		logic [1:0]        op;
		logic [PIN_FW-1:0] pin;
		logic [LVL_W-1:0]  level;
	} mpp_req_t;

	typedef struct packed {
		logic [31:0]      change_mask;
		logic [31:0]      pin_values;
		logic             all_steady;
		logic [LVL_W-1:0] duty_readback;
	} mpp_rsp_t;

	typedef struct packed {
		logic              rd_en;
		logic [PIN_FW-1:0] rd_addr;
		logic              wr_en;
		logic [PIN_FW-1:0] wr_addr;
		logic [LVL_W-1:0]  wr_lvl;
	} mpp_mem_req_t;

	// pattern k has k one bits spread evenly; levels above 32 never reach here
	function automatic logic [PAT_W-1:0] pattern_rom(input logic [LVL_W-1:0] lvl);
		logic [PAT_W-1:0] p;
		case (lvl)
			6'd0:  p = 32'h00000000;
			6'd1:  p = 32'h80000000;
			6'd2:  p = 32'h80008000;
			6'd3:  p = 32'h80100200;
			6'd4:  p = 32'h80808080;
			6'd5:  p = 32'h82081040;
			6'd6:  p = 32'h84208420;
			6'd7:  p = 32'h88442210;
			6'd8:  p = 32'h88888888;
			6'd9:  p = 32'h91224488;
			6'd10: p = 32'h89248924;
			6'd11: p = 32'hA4924924;
			6'd12: p = 32'h92929292;
			6'd13: p = 32'hA5294A52;
			6'd14: p = 32'hAA52A94A;
			6'd15: p = 32'hAAA5552A;
			6'd16: p = 32'hAAAAAAAA;
			6'd17: p = 32'hD5556AAA;
			6'd18: p = 32'hD56AD56A;
			6'd19: p = 32'hD6B5AD6A;
			6'd20: p = 32'hDADADADA;
			6'd21: p = 32'hDB6DB6DA;
			6'd22: p = 32'hEDB6EDB6;
			6'd23: p = 32'hEDDBB776;
			6'd24: p = 32'hEEEEEEEE;
			6'd25: p = 32'hF77BBDEE;
			6'd26: p = 32'hF7DEFBDE;
			6'd27: p = 32'hFBF7DFBE;
			6'd28: p = 32'hFEFEFEFE;
			6'd29: p = 32'hFFDFFBFE;
			6'd30: p = 32'hFFFEFFFE;
			6'd31: p = 32'hFFFFFFFE;
			default: p = 32'hFFFFFFFF;
		endcase
		return p;
	endfunction

endpackage

// ----- design/mpp_lvl_store.sv -----
// Per-pin level memory with valid bits; unwritten pins read as level zero.
module mpp_lvl_store import mpp_pkg::*; #(
	parameter int NUM_PINS = 32,
	parameter int PIN_W    = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mpp_mem_req_t     mreq,
	output logic [LVL_W-1:0] rd_lvl
);

	logic [LVL_W-1:0]    lvl_mem_q [NUM_PINS];
	logic [NUM_PINS-1:0] vld_q;
	logic [LVL_W-1:0]    data_s1;
	logic                vld_s1;

	always_ff @(posedge clk) begin
		if (mreq.wr_en)
			lvl_mem_q[mreq.wr_addr[PIN_W-1:0]] <= mreq.wr_lvl;
		if (mreq.rd_en)
			data_s1 <= lvl_mem_q[mreq.rd_addr[PIN_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (mreq.wr_en)
				vld_q[mreq.wr_addr[PIN_W-1:0]] <= 1'b1;
			if (mreq.rd_en)
				vld_s1 <= vld_q[mreq.rd_addr[PIN_W-1:0]];
		end
	end

	assign rd_lvl = vld_s1 ? data_s1 : '0;

endmodule

// ----- design/multichannel_pattern_pwm.sv -----
// Top level of the multichannel pattern PWM engine.
//
//  channel | signals                    | direction | payload
//  req     | req_valid req_stall req    | in        | mpp_req_t (op, pin, level)
//  rsp     | rsp_valid rsp_stall rsp    | out       | mpp_rsp_t (mask, values, steady, duty)
//
// Tick: one level memory read per pin walks the pins in order, then drain and finish.
// Set and read: a read of one memory entry; set writes the new level back to it.
// Unused opcode or absent pin: straight to the result.
// One item at a time; the next transfer is taken once the result sits in the output register.
// A result held by rsp_stall stalls only the finish of the following item.
// Reset clears levels (through valid bits), pin outputs, phase and the unsteady count.
module multichannel_pattern_pwm import mpp_pkg::*; #(
	parameter int NUM_PINS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  mpp_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output mpp_rsp_t rsp
);

	`include "multichannel_pattern_pwm_assert.svh"

	localparam int PIN_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
	localparam int CNT_W = $clog2(NUM_PINS + 1);
	localparam logic [PIN_W-1:0] LAST_PIN = PIN_W'(NUM_PINS - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RMW   = 3'd1;
	localparam logic [2:0] ST_WALK  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]          state_q;
	logic [1:0]          op_q;
	logic [PIN_W-1:0]    pin_q;
	logic [LVL_W-1:0]    lvl_q;
	logic [4:0]          phase_q;
	logic [PIN_W-1:0]    idx_q;
	logic [PIN_W-1:0]    idx_s1;
	logic                walk_s1;
	logic [CNT_W-1:0]    ns_cnt_q;
	logic                steady_q;
	logic [NUM_PINS-1:0] mask_q;
	logic [NUM_PINS-1:0] vals_q;
	logic [LVL_W-1:0]    duty_q;
	logic [NUM_PINS-1:0] pin_out_q;
	mpp_rsp_t            rsp_q;
	logic                rsp_valid_q;

	mpp_mem_req_t     mreq;
	logic [LVL_W-1:0] rd_lvl;
	logic             accept;
	logic             pin_ok;
	logic [LVL_W-1:0] sat_lvl;
	logic [PAT_W-1:0] cur_pat;
	logic             cur_bit;
	logic             old_ns;
	logic             new_ns;
	logic             fin_go;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign pin_ok    = (6'(req.pin) < 6'(NUM_PINS));
	assign sat_lvl   = (req.level > LVL_MAX) ? LVL_MAX : req.level;
	assign cur_pat   = pattern_rom(rd_lvl);
	assign cur_bit   = cur_pat[phase_q];
	assign old_ns    = (rd_lvl != '0) && (rd_lvl != LVL_MAX);
	assign new_ns    = (lvl_q != '0) && (lvl_q != LVL_MAX);
	assign fin_go    = (state_q == ST_FIN) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		mreq = '0;
		if (accept && pin_ok && (req.op == OP_SET || req.op == OP_READ)) begin
			mreq.rd_en   = 1'b1;
			mreq.rd_addr = req.pin;
		end
		if (state_q == ST_WALK) begin
			mreq.rd_en   = 1'b1;
			mreq.rd_addr = PIN_FW'(idx_q);
		end
		if (state_q == ST_RMW && op_q == OP_SET) begin
			mreq.wr_en   = 1'b1;
			mreq.wr_addr = PIN_FW'(pin_q);
			mreq.wr_lvl  = lvl_q;
		end
	end

	mpp_lvl_store #(
		.NUM_PINS(NUM_PINS),
		.PIN_W   (PIN_W)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.mreq  (mreq),
		.rd_lvl(rd_lvl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			walk_s1     <= 1'b0;
			ns_cnt_q    <= '0;
			pin_out_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			walk_s1 <= (state_q == ST_WALK);
			if (walk_s1)
				pin_out_q[idx_s1] <= cur_bit;
			if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.op)
							OP_TICK: begin
								phase_q <= phase_q - 5'd1;
								state_q <= ST_WALK;
							end
							OP_SET, OP_READ: state_q <= pin_ok ? ST_RMW : ST_FIN;
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_RMW: begin
					if (op_q == OP_SET)
						ns_cnt_q <= ns_cnt_q + CNT_W'(new_ns) - CNT_W'(old_ns);
					state_q <= ST_FIN;
				end
				ST_WALK: begin
					if (idx_q == LAST_PIN)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (accept) begin
			op_q     <= req.op;
			pin_q    <= req.pin[PIN_W-1:0];
			lvl_q    <= sat_lvl;
			steady_q <= (ns_cnt_q == '0);
			mask_q   <= '0;
			vals_q   <= '0;
			duty_q   <= '0;
			idx_q    <= '0;
		end
		if (state_q == ST_WALK)
			idx_q <= idx_q + PIN_W'(1);
		if (state_q == ST_RMW && op_q == OP_READ)
			duty_q <= rd_lvl;
		if (walk_s1 && (cur_bit != pin_out_q[idx_s1])) begin
			mask_q[idx_s1] <= 1'b1;
			vals_q[idx_s1] <= cur_bit;
		end
		if (fin_go) begin
			rsp_q.change_mask   <= 32'(mask_q);
			rsp_q.pin_values    <= 32'(vals_q);
			rsp_q.all_steady    <= steady_q;
			rsp_q.duty_readback <= duty_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`MPP_ASSERT_IMP(a_cnt_bound, 1'b1, ns_cnt_q <= CNT_W'(NUM_PINS))
	`MPP_ASSERT_IMP(a_walk_state, walk_s1, state_q == ST_WALK || state_q == ST_DRAIN)
	`MPP_ASSERT_NXT(a_busy_after_accept, accept, req_stall)

endmodule
